FILE: sv/stream_literal_replace_top_defines.svh
// assertion macros for the literal replace block
// used by the checker bound to stream_literal_replace_top
`ifndef STREAM_LITERAL_REPLACE_TOP_DEFINES_SVH
`define STREAM_LITERAL_REPLACE_TOP_DEFINES_SVH

// clocked check, off while in reset
`define SLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slr check failed");

// clocked check, also active during reset
`define SLR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("slr check failed during reset");

`endif

FILE: sv/slr_pkg.sv
// types, constants and helpers of the literal replace block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int MAX_PATTERN_BYTES     = 8;
  localparam int MAX_REPLACEMENT_BYTES = 8;
  localparam int WIN_W                 = 8 * MAX_PATTERN_BYTES;
  localparam int REP_W                 = 8 * MAX_REPLACEMENT_BYTES;
  localparam int LEN_W                 = 4;
  localparam int FILL_W                = 3;
  localparam int CFG_W                 = 64;
  localparam int FIFO_DEPTH            = 2;
  localparam int FIFO_PTR_W            = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_e;

  // bytes to emit for one input transaction
  typedef struct packed {
    logic [WIN_W-1:0] bytes;
    logic [LEN_W-1:0] count;
    logic             eos;
  } desc_t;

  function automatic logic [WIN_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [WIN_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/slr_if.sv
// stream channels of the literal replace block: input bytes and result bytes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface slr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface slr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input stream_done,
                output ready);
endinterface

`default_nettype wire

FILE: sv/slr_front.sv
// front end: config registers, match window and classification of each input
// depends on slr_pkg and slr_in_if
`timescale 1ns / 1ps
`default_nettype none

module slr_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  slr_in_if.sink                  in_ch,
  input  wire                     cfg_we_i,
  input  slr_pkg::cfg_idx_e       cfg_idx_i,
  input  wire [slr_pkg::CFG_W-1:0] cfg_data_i,
  input  wire                     fifo_full_i,
  output logic                    push_o,
  output slr_pkg::desc_t          desc_o
);

  logic [slr_pkg::WIN_W-1:0]  pat_q;
  logic [slr_pkg::LEN_W-1:0]  plen_q;
  logic [slr_pkg::REP_W-1:0]  rep_q;
  logic [slr_pkg::LEN_W-1:0]  rlen_q;
  logic [slr_pkg::WIN_W-1:0]  win_q, win_d;
  logic [slr_pkg::FILL_W-1:0] fill_q, fill_d;

  logic [slr_pkg::LEN_W-1:0]  plen_eff, rlen_eff, fill_a;
  logic [slr_pkg::WIN_W-1:0]  w_app;
  logic                       accept, hit, shift, eos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= slr_pkg::LEN_W'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slr_pkg::CFG_PATTERN_BYTES:      pat_q  <= cfg_data_i[slr_pkg::WIN_W-1:0];
        slr_pkg::CFG_PATTERN_LENGTH:     plen_q <= cfg_data_i[slr_pkg::LEN_W-1:0];
        slr_pkg::CFG_REPLACEMENT_BYTES:  rep_q  <= cfg_data_i[slr_pkg::REP_W-1:0];
        slr_pkg::CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data_i[slr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plen_q == '0) begin
      plen_eff = slr_pkg::LEN_W'(1);
    end else if (plen_q > slr_pkg::LEN_W'(slr_pkg::MAX_PATTERN_BYTES)) begin
      plen_eff = slr_pkg::LEN_W'(slr_pkg::MAX_PATTERN_BYTES);
    end else begin
      plen_eff = plen_q;
    end
    if (rlen_q > slr_pkg::LEN_W'(slr_pkg::MAX_REPLACEMENT_BYTES)) begin
      rlen_eff = slr_pkg::LEN_W'(slr_pkg::MAX_REPLACEMENT_BYTES);
    end else begin
      rlen_eff = rlen_q;
    end
  end

  assign in_ch.ready = !fifo_full_i;
  assign accept      = in_ch.valid && !fifo_full_i;
  assign eos         = in_ch.end_of_stream;
  assign fill_a      = {1'b0, fill_q} + slr_pkg::LEN_W'(1);

  always_comb begin
    w_app = win_q;
    w_app[{fill_q, 3'b000} +: 8] = in_ch.data_byte;
  end

  assign hit   = (fill_a == plen_eff) &&
                 (((w_app ^ pat_q) & slr_pkg::byte_mask(plen_eff)) == '0);
  assign shift = (fill_a > plen_eff) || ((fill_a == plen_eff) && !hit);

  always_comb begin
    desc_o.eos   = eos;
    desc_o.bytes = hit ? rep_q : w_app;
    if (hit) begin
      desc_o.count = rlen_eff;
    end else if (eos) begin
      desc_o.count = fill_a;
    end else if (shift) begin
      desc_o.count = slr_pkg::LEN_W'(1);
    end else begin
      desc_o.count = '0;
    end
  end

  assign push_o = accept && (desc_o.count != '0);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      if (eos || hit) begin
        win_d  = '0;
        fill_d = '0;
      end else if (shift) begin
        win_d  = w_app >> 8;
        fill_d = fill_q;
      end else begin
        win_d  = w_app;
        fill_d = fill_a[slr_pkg::FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/slr_fifo.sv
// short queue of emit descriptors between front and back
// depends on slr_pkg
`timescale 1ns / 1ps
`default_nettype none

module slr_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  slr_pkg::desc_t push_desc_i,
  input  wire            pop_i,
  output logic           full_o,
  output logic           valid_o,
  output slr_pkg::desc_t head_o
);

  slr_pkg::desc_t                mem_q [slr_pkg::FIFO_DEPTH];
  logic [slr_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [slr_pkg::FIFO_PTR_W:0]   cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (slr_pkg::FIFO_PTR_W+1)'(slr_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= slr_pkg::FIFO_PTR_W'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= slr_pkg::FIFO_PTR_W'(rd_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/slr_back.sv
// back end: sends the bytes of the head descriptor one transaction each
// depends on slr_pkg and slr_out_if
`timescale 1ns / 1ps
`default_nettype none

module slr_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            head_valid_i,
  input  slr_pkg::desc_t head_i,
  output logic           pop_o,
  slr_out_if.source      out_ch
);

  logic [slr_pkg::FILL_W-1:0] idx_q, idx_d;
  logic                       last, fire;

  assign last = (({1'b0, idx_q} + slr_pkg::LEN_W'(1)) == head_i.count);
  assign fire = head_valid_i && out_ch.ready;

  assign out_ch.valid       = head_valid_i;
  assign out_ch.out_byte    = head_i.bytes[{idx_q, 3'b000} +: 8];
  assign out_ch.last_of_run = last;
  assign out_ch.stream_done = last && head_i.eos;
  assign pop_o              = fire && last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? '0 : slr_pkg::FILL_W'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/stream_literal_replace_top.sv
// top level of the streaming literal find-and-replace block
// depends on slr_pkg, slr_if, slr_front, slr_fifo, slr_back
//
//   channel   dir   transaction payload
//   in_ch     in    data_byte, end_of_stream
//   out_ch    out   out_byte, last_of_run, stream_done
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// one input byte per cycle while the two-entry descriptor queue has room
// an input emitting n bytes holds the output side for n transactions, one byte per cycle while out_ch is ready
// input to first output byte: registered in the descriptor queue
// asynchronous reset empties window and queue, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module stream_literal_replace_top (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  slr_in_if.sink                   in_ch,
  slr_out_if.source                out_ch,
  input  wire                      cfg_we_i,
  input  slr_pkg::cfg_idx_e        cfg_idx_i,
  input  wire [slr_pkg::CFG_W-1:0] cfg_data_i
);

  slr_pkg::desc_t push_desc, head_desc;
  logic           push, pop, full, head_valid;

  slr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_full_i (full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  slr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head_desc)
  );

  slr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_desc),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/slr_checker.sv
// port-level checks of stream_literal_replace_top and their bind
// depends on stream_literal_replace_top_defines.svh and the top level
`timescale 1ns / 1ps
`default_nettype none
`include "stream_literal_replace_top_defines.svh"

module slr_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] out_byte_i,
  input wire       out_last_i,
  input wire       out_done_i
);

  `SLR_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_i)
  `SLR_ASSERT(a_out_needs_input, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
  `SLR_ASSERT(a_ready_when_drained, !out_valid_i |-> in_ready_i)
  `SLR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i) && $stable(out_done_i))

endmodule

bind stream_literal_replace_top slr_checker u_slr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_byte_i  (out_ch.out_byte),
  .out_last_i  (out_ch.last_of_run),
  .out_done_i  (out_ch.stream_done)
);

`default_nettype wire
